>>> rtl/core/sdspi_pkg.sv
// Shared types and constants for the SD-card SPI command engine.
// Used by every module under rtl/core; depends on nothing else.
package sdspi_pkg;

  // Item kinds carried on the slave tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Frame layout and command constants
  localparam logic [5:0] FRAME_BITS   = 6'd48;
  localparam logic [5:0] BYTE_BITS    = 6'd8;
  localparam logic [1:0] CMD_PREFIX   = 2'b01;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;
  localparam logic [7:0] CRC_IF_COND  = 8'h87;
  localparam logic [7:0] CRC_DEFAULT  = 8'h95;
  localparam logic [7:0] BYTE_IDLE    = 8'hFF;
  localparam logic [2:0] OCR_BYTES    = 3'd4;

  // Configuration register map
  localparam logic       REG_WAIT_LIMIT  = 1'b0;
  localparam logic [8:0] WAIT_LIMIT_RST  = 9'd256;

  // Bit widths of the stream payloads
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // One accepted input transaction
  typedef struct packed {
    logic        cmd;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic        miso_bit;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic       mosi_bit;
    logic       select_active;
    logic       busy_res;
    logic       done_res;
    logic [7:0] response_byte;
    logic       high_capacity;
    logic       timed_out;
  } result_t;

endpackage

>>> rtl/core/sd_spi_command_engine.sv
// Top level of the SD-card SPI command engine: stream ports, APB register.
// Depends on sdspi_pkg, sdspi_cfg, sdspi_in_stage, sdspi_engine, sdspi_out_stage.
//
// Usage: each slave stream transaction is one item. tuser low starts a
// command (index and argument in tdata); tuser high is one serial clock tick
// carrying the sampled MISO bit. Every item yields exactly one master stream
// transaction with the MOSI bit to drive, select/busy/done flags, the R1
// response and timeout flag on the finishing tick, and the OCR capacity flag.
// A start frame sends 48 bits, then skips one byte, then polls up to wait_limit
// bytes (at least one), plus four OCR bytes after command 58 answers 0x00.
// An accepted item is loaded into the input register, then moved through
// the engine into the output register once that register is free.
// Throughput is one item per cycle while the receiver takes results; the engine state updates in one pass.
// When the receiver stalls, the output register holds its result and the
// input register keeps its item (taking one more first if empty), after which tready drops.
// Reset empties both registers and returns the engine to idle with the
// poll limit at 256 and the capacity flag cleared.
module sd_spi_command_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [sdspi_pkg::IN_DATA_W-1:0] s_axis_tdata,  // command_index[5:0],
                                     // argument[37:6], miso_bit[38], pad
  input  logic        s_axis_tuser,  // cmd
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [sdspi_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // mosi_bit, select_active,
                                     // busy_res, done_res, response_byte[11:4],
                                     // high_capacity, timed_out, pad
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sdspi_pkg::item_t   in_item, held_item;
  sdspi_pkg::result_t eng_result, out_result;
  logic               held_valid;
  logic               out_free;
  logic               advance;
  logic [8:0]         wait_limit;

  // Unpack the slave payload
  always_comb begin
    in_item.cmd           = s_axis_tuser;
    in_item.command_index = s_axis_tdata[5:0];
    in_item.argument      = s_axis_tdata[37:6];
    in_item.miso_bit      = s_axis_tdata[38];
  end

  assign advance = held_valid && out_free;

  sdspi_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .wait_limit_o (wait_limit)
  );

  sdspi_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  sdspi_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .item_i       (held_item),
    .wait_limit_i (wait_limit),
    .result_o     (eng_result)
  );

  sdspi_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (eng_result),
    .ready_i  (m_axis_tready),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result)
  );

  // Pack the master payload, first field lowest
  assign m_axis_tdata = {2'b00,
                         out_result.timed_out,
                         out_result.high_capacity,
                         out_result.response_byte,
                         out_result.done_res,
                         out_result.busy_res,
                         out_result.select_active,
                         out_result.mosi_bit};

endmodule

>>> rtl/core/sdspi_cfg.sv
// APB-style configuration register holding the response poll limit.
// Depends on sdspi_pkg for the register map and reset value.
module sdspi_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  wait_limit_o
);

  logic [8:0] wait_limit_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == sdspi_pkg::REG_WAIT_LIMIT);

  // Capture the limit on the access cycle of a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_limit_q <= sdspi_pkg::WAIT_LIMIT_RST;
    end else if (wr_en) begin
      wait_limit_q <= pwdata[8:0];
    end
  end

  // Read back the register, zero beyond the map
  always_comb begin
    if (paddr[2] == sdspi_pkg::REG_WAIT_LIMIT) begin
      prdata = {23'd0, wait_limit_q};
    end else begin
      prdata = 32'd0;
    end
  end

  assign wait_limit_o = wait_limit_q;

endmodule

>>> rtl/core/sdspi_in_stage.sv
// Input register of the command engine: holds one accepted transaction.
// Depends on sdspi_pkg for the item type.
module sdspi_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sdspi_pkg::item_t  item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output sdspi_pkg::item_t  item_o
);

  logic             valid_q;
  sdspi_pkg::item_t item_q;

  // Take a new transaction when empty or when the held one moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/core/sdspi_engine.sv
// Command engine state: frame shifter, byte receiver, poll and OCR control.
// Depends on sdspi_pkg for item/result types and protocol constants.
module sdspi_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sdspi_pkg::item_t    item_i,
  input  logic [8:0]          wait_limit_i,
  output sdspi_pkg::result_t  result_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SEND = 3'd1;
  localparam logic [2:0] PH_SKIP = 3'd2;
  localparam logic [2:0] PH_POLL = 3'd3;
  localparam logic [2:0] PH_OCR  = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [47:0] send_q, send_d;
  logic [5:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  rx_q, rx_d;
  logic [8:0]  poll_cnt_q, poll_cnt_d;
  logic [2:0]  ocr_cnt_q, ocr_cnt_d;
  logic        is_ocr_q, is_ocr_d;
  logic [7:0]  last_resp_q, last_resp_d;
  logic        cap_q, cap_d;

  logic [5:0]  bit_inc;
  logic [7:0]  rx_byte;
  logic [8:0]  poll_inc;
  logic [8:0]  limit;
  logic [2:0]  ocr_inc;
  logic [7:0]  crc;
  logic        mosi, sel, busy, done;

  assign bit_inc  = bit_cnt_q + 6'd1;
  assign rx_byte  = {rx_q[6:0], item_i.miso_bit};
  assign poll_inc = poll_cnt_q + 9'd1;
  assign limit    = (wait_limit_i == 9'd0) ? 9'd1 : wait_limit_i;
  assign ocr_inc  = ocr_cnt_q + 3'd1;
  assign crc      = (item_i.command_index == sdspi_pkg::CMD_IF_COND) ?
                    sdspi_pkg::CRC_IF_COND : sdspi_pkg::CRC_DEFAULT;

  // Next state and result for the transaction in the input register
  always_comb begin
    phase_d     = phase_q;
    send_d      = send_q;
    bit_cnt_d   = bit_cnt_q;
    rx_d        = rx_q;
    poll_cnt_d  = poll_cnt_q;
    ocr_cnt_d   = ocr_cnt_q;
    is_ocr_d    = is_ocr_q;
    last_resp_d = last_resp_q;
    cap_d       = cap_q;
    mosi        = 1'b1;
    sel         = 1'b0;
    busy        = 1'b0;
    done        = 1'b0;

    if (item_i.cmd == sdspi_pkg::CMD_START) begin
      // Load a fresh frame, dropping any running command
      send_d     = {sdspi_pkg::CMD_PREFIX, item_i.command_index, item_i.argument, crc};
      bit_cnt_d  = 6'd0;
      rx_d       = 8'd0;
      poll_cnt_d = 9'd0;
      ocr_cnt_d  = 3'd0;
      is_ocr_d   = (item_i.command_index == sdspi_pkg::CMD_READ_OCR);
      phase_d    = PH_SEND;
      sel        = 1'b1;
      busy       = 1'b1;
    end else if (phase_q inside {PH_SEND, PH_SKIP, PH_POLL, PH_OCR}) begin
      sel  = 1'b1;
      busy = 1'b1;
      if (phase_q == PH_SEND) begin
        // Shift the frame out MSB first
        mosi      = send_q[47];
        send_d    = {send_q[46:0], 1'b0};
        bit_cnt_d = bit_inc;
        if (bit_inc >= sdspi_pkg::FRAME_BITS) begin
          bit_cnt_d = 6'd0;
          phase_d   = PH_SKIP;
        end
      end else begin
        // Gather one byte from the card
        rx_d      = rx_byte;
        bit_cnt_d = bit_inc;
        if (bit_inc >= sdspi_pkg::BYTE_BITS) begin
          bit_cnt_d = 6'd0;
          rx_d      = 8'd0;
          case (phase_q)
            PH_SKIP: begin
              phase_d = PH_POLL;
            end
            PH_POLL: begin
              last_resp_d = rx_byte;
              poll_cnt_d  = poll_inc;
              if (rx_byte != sdspi_pkg::BYTE_IDLE || poll_inc >= limit) begin
                if (rx_byte == 8'd0 && is_ocr_q) begin
                  ocr_cnt_d = 3'd0;
                  phase_d   = PH_OCR;
                end else begin
                  phase_d = PH_IDLE;
                  busy    = 1'b0;
                  done    = 1'b1;
                end
              end
            end
            default: begin
              // OCR bytes: capacity bit sits in the first one
              if (ocr_cnt_q == 3'd0) begin
                cap_d = rx_byte[6];
              end
              ocr_cnt_d = ocr_inc;
              if (ocr_inc >= sdspi_pkg::OCR_BYTES) begin
                phase_d = PH_IDLE;
                busy    = 1'b0;
                done    = 1'b1;
              end
            end
          endcase
        end
      end
    end else begin
      phase_d = PH_IDLE;
    end
  end

  always_comb begin
    result_o.mosi_bit      = mosi;
    result_o.select_active = sel;
    result_o.busy_res      = busy;
    result_o.done_res      = done;
    result_o.response_byte = done ? last_resp_d : 8'd0;
    result_o.high_capacity = cap_d;
    result_o.timed_out     = done && (last_resp_d == sdspi_pkg::BYTE_IDLE);
  end

  // Advance the engine once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      send_q      <= 48'd0;
      bit_cnt_q   <= 6'd0;
      rx_q        <= 8'd0;
      poll_cnt_q  <= 9'd0;
      ocr_cnt_q   <= 3'd0;
      is_ocr_q    <= 1'b0;
      last_resp_q <= sdspi_pkg::BYTE_IDLE;
      cap_q       <= 1'b0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      send_q      <= send_d;
      bit_cnt_q   <= bit_cnt_d;
      rx_q        <= rx_d;
      poll_cnt_q  <= poll_cnt_d;
      ocr_cnt_q   <= ocr_cnt_d;
      is_ocr_q    <= is_ocr_d;
      last_resp_q <= last_resp_d;
      cap_q       <= cap_d;
    end
  end

`ifndef SYNTH
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.done_res |=> phase_q == PH_IDLE)
    else $error("engine not idle after finishing a command");
  a_send_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SEND |-> bit_cnt_q < sdspi_pkg::FRAME_BITS)
    else $error("frame bit counter out of range");
  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP || phase_q == PH_POLL || phase_q == PH_OCR)
    |-> bit_cnt_q < sdspi_pkg::BYTE_BITS)
    else $error("byte bit counter out of range");
  a_ocr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_OCR |-> ocr_cnt_q < sdspi_pkg::OCR_BYTES && last_resp_q == 8'd0)
    else $error("OCR read entered without a clean response");
  a_start_selects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == sdspi_pkg::CMD_START |=> phase_q == PH_SEND && bit_cnt_q == 6'd0)
    else $error("start did not open a frame");
`endif

endmodule

>>> rtl/core/sdspi_out_stage.sv
// Output register of the command engine: holds one result until taken.
// Depends on sdspi_pkg for the result type.
module sdspi_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sdspi_pkg::result_t  result_i,
  input  logic                ready_i,
  output logic                free_o,
  output logic                valid_o,
  output sdspi_pkg::result_t  result_o
);

  logic               valid_q;
  sdspi_pkg::result_t result_q;

  // Room for a new result when empty or being drained this cycle
  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
